// ----- hw/rtl/urm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urm_pkg
// Shared types and constants for the USART register model.
// ----------------------------------------------------------------------------
package urm_pkg;

  localparam int unsigned RxDepthDefault = 16;
  localparam int unsigned TxDepthDefault = 4;

  localparam logic [15:0] DelayReset = 16'd100;
  localparam logic [7:0]  HeldReset  = 8'hff;

  // status bit positions
  localparam int unsigned StTxRdy  = 0;
  localparam int unsigned StRxRdy  = 1;
  localparam int unsigned StTxE    = 2;
  localparam int unsigned StPe     = 3;
  localparam int unsigned StOe     = 4;
  localparam int unsigned StFe     = 5;
  localparam int unsigned StSynDet = 6;
  localparam int unsigned StDsr    = 7;

  localparam logic [7:0] StatusReset = 8'h05;

  // mode phases
  localparam logic [2:0] PhClear = 3'd0;
  localparam logic [2:0] PhSync  = 3'd1;
  localparam logic [2:0] PhAsync = 3'd2;
  localparam logic [2:0] PhSync1 = 3'd3;
  localparam logic [2:0] PhSync2 = 3'd4;

  // item commands
  localparam logic [2:0] CmdWrite = 3'd0;
  localparam logic [2:0] CmdRead  = 3'd1;
  localparam logic [2:0] CmdByte  = 3'd2;
  localparam logic [2:0] CmdBreak = 3'd3;
  localparam logic [2:0] CmdDsr   = 3'd4;
  localparam logic [2:0] CmdClear = 3'd5;
  localparam logic [2:0] CmdTick  = 3'd6;

  // configuration register indexes
  localparam logic CfgDelay    = 1'b0;
  localparam logic CfgLoopback = 1'b1;

  // receive queue entry: bit 8 marks a break
  localparam int unsigned RxEntryW = 9;
  localparam int unsigned BreakBit = 8;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } urm_qctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/urm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module urm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/urm_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urm_queue
// Circular queue in a RAM; the head entry is prefetched every cycle and
// a write to the entry being fetched is forwarded.
// ----------------------------------------------------------------------------
module urm_queue #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire urm_pkg::urm_qctl_t ctl_i,
  input  wire logic [DW-1:0]     push_data_i,
  output logic      [DW-1:0]     head_data_o,
  output logic      [CW-1:0]     count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW = CW + 1;

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          fwd_q, fwd_d;
  logic [DW-1:0] fwd_data_q;
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail;
  logic [DW-1:0] rdata;

  always_comb begin
    tail_sum = SW'(head_q) + SW'(count_q);
    if (tail_sum >= SW'(DEPTH)) begin
      tail_sum = tail_sum - SW'(DEPTH);
    end
    tail = tail_sum[AW-1:0];
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (ctl_i.clear) begin
      head_d  = '0;
      count_d = '0;
    end else begin
      if (ctl_i.pop) begin
        head_d = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
      end
      count_d = count_q + CW'(ctl_i.push) - CW'(ctl_i.pop);
    end
    fwd_d = ctl_i.push && (tail == head_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      fwd_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      fwd_q   <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= push_data_i;
  end

  urm_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.push),
    .waddr_i (tail),
    .wdata_i (push_data_i),
    .raddr_i (head_d),
    .rdata_o (rdata)
  );

  assign head_data_o = fwd_q ? fwd_data_q : rdata;
  assign count_o     = count_q;

endmodule
`default_nettype wire

// ----- hw/rtl/usart_register_model.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usart_register_model
// Register-level USART model: bus access, line input, event countdowns.
// ----------------------------------------------------------------------------
// One item is accepted per clock cycle and its result is presented in an
// output register on the following cycle; a new item is taken while that
// result waits unless the result is stalled. Each item is a single
// read-modify-write of the control registers plus at most one pop and one
// push per queue; both queues sit in RAMs whose head entry is prefetched
// every cycle with write forwarding, so the single RAM read port sets the
// one-item-per-cycle figure. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module usart_register_model #(
  parameter int unsigned RX_DEPTH = urm_pkg::RxDepthDefault,
  parameter int unsigned TX_DEPTH = urm_pkg::TxDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  command_i,
  input  wire logic        addr_i,
  input  wire logic [7:0]  data_i,
  input  wire logic        level_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [7:0]  read_data_o,
  output logic      [7:0]  status_byte_o,
  output logic             dtr_out_o,
  output logic             rts_out_o,
  output logic             tx_valid_o,
  output logic      [7:0]  tx_byte_o,
  output logic             rx_dropped_o
);

  localparam int unsigned RXCW = $clog2(RX_DEPTH + 1);
  localparam int unsigned TXCW = $clog2(TX_DEPTH + 1);
  localparam int unsigned RXW  = urm_pkg::RxEntryW;

  logic [15:0] delay_q;
  logic        loop_q;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  held_q, held_d;
  logic [7:0]  status_q, status_d;
  logic        rx_en_q, rx_en_d;
  logic        tx_en_q, tx_en_d;
  logic        dtr_q, dtr_d;
  logic        rts_q, rts_d;
  logic [15:0] rx_timer_q, rx_timer_d;
  logic [15:0] tx_timer_q, tx_timer_d;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  rd_q, rd_d;
  logic [7:0]  txb_q, txb_d;
  logic        txv_q, txv_d;
  logic        drop_q, drop_d;

  urm_pkg::urm_qctl_t rxq_ctl, txq_ctl;
  logic [RXW-1:0]  rxq_wdata, rxq_head;
  logic [7:0]      txq_wdata, txq_head;
  logic [RXCW-1:0] rx_count, rx_cnt1;
  logic [TXCW-1:0] tx_count, tx_cnt1;

  logic        accept;
  logic [15:0] delay_val;
  logic        rx_fire, tx_fire;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign delay_val  = (delay_q == 16'd0) ? 16'd1 : delay_q;

  always_comb begin
    phase_d    = phase_q;
    held_d     = held_q;
    status_d   = status_q;
    rx_en_d    = rx_en_q;
    tx_en_d    = tx_en_q;
    dtr_d      = dtr_q;
    rts_d      = rts_q;
    rx_timer_d = rx_timer_q;
    tx_timer_d = tx_timer_q;
    rxq_ctl    = '0;
    txq_ctl    = '0;
    rxq_wdata  = {1'b0, data_i};
    txq_wdata  = data_i;
    rd_d       = 8'd0;
    txv_d      = 1'b0;
    txb_d      = 8'd0;
    drop_d     = 1'b0;
    rx_fire    = 1'b0;
    tx_fire    = 1'b0;
    rx_cnt1    = rx_count;
    tx_cnt1    = tx_count;

    if (accept) begin
      case (command_i)
        urm_pkg::CmdWrite: begin
          if (addr_i) begin
            case (phase_q)
              urm_pkg::PhClear: begin
                if (data_i[1:0] != 2'b00) begin
                  phase_d = urm_pkg::PhAsync;
                end else if (data_i[7]) begin
                  phase_d = urm_pkg::PhSync2;
                end else begin
                  phase_d = urm_pkg::PhSync1;
                end
              end
              urm_pkg::PhSync1: phase_d = urm_pkg::PhSync2;
              urm_pkg::PhSync2: phase_d = urm_pkg::PhSync;
              urm_pkg::PhAsync, urm_pkg::PhSync: begin
                if (data_i[6]) begin
                  phase_d = urm_pkg::PhClear;
                end else begin
                  if (data_i[4]) begin
                    status_d[urm_pkg::StFe:urm_pkg::StPe] = 3'b000;
                  end
                  dtr_d   = data_i[1];
                  rts_d   = data_i[3];
                  rx_en_d = data_i[2];
                  tx_en_d = data_i[0];
                  if (data_i[2] && rx_count != '0 && rx_timer_q == 16'd0) begin
                    rx_timer_d = delay_val;
                  end
                  if (data_i[0] && tx_count != '0 && tx_timer_q == 16'd0) begin
                    tx_timer_d = delay_val;
                  end
                end
              end
              default: begin
              end
            endcase
          end else if (status_q[urm_pkg::StTxRdy] && tx_count < TXCW'(TX_DEPTH)) begin
            txq_ctl.push = 1'b1;
            if (tx_count + TXCW'(1) == TXCW'(TX_DEPTH)) begin
              status_d[urm_pkg::StTxRdy] = 1'b0;
            end
            status_d[urm_pkg::StTxE] = 1'b0;
            if (tx_en_q && tx_timer_q == 16'd0) begin
              tx_timer_d = delay_val;
            end
          end
        end
        urm_pkg::CmdRead: begin
          if (addr_i) begin
            rd_d = status_q;
          end else begin
            status_d[urm_pkg::StRxRdy] = 1'b0;
            rd_d = held_q;
          end
        end
        urm_pkg::CmdByte, urm_pkg::CmdBreak: begin
          if (command_i == urm_pkg::CmdBreak) begin
            rxq_wdata = RXW'(1) << urm_pkg::BreakBit;
          end
          if (rx_count == RXCW'(RX_DEPTH)) begin
            drop_d = 1'b1;
          end else begin
            rxq_ctl.push = 1'b1;
            if (rx_en_q && rx_timer_q == 16'd0) begin
              rx_timer_d = delay_val;
            end
          end
        end
        urm_pkg::CmdDsr: begin
          status_d[urm_pkg::StDsr] = level_i;
        end
        urm_pkg::CmdClear: begin
          rxq_ctl.clear = 1'b1;
        end
        urm_pkg::CmdTick: begin
          if (rx_timer_q != 16'd0) begin
            rx_timer_d = rx_timer_q - 16'd1;
            rx_fire    = (rx_timer_q == 16'd1);
          end
          if (tx_timer_q != 16'd0) begin
            tx_timer_d = tx_timer_q - 16'd1;
            tx_fire    = (tx_timer_q == 16'd1);
          end
          if (rx_fire) begin
            if (rx_en_q && !status_q[urm_pkg::StRxRdy] && rx_count != '0) begin
              rxq_ctl.pop = 1'b1;
              rx_cnt1     = rx_count - RXCW'(1);
              if (rxq_head[urm_pkg::BreakBit]) begin
                status_d[urm_pkg::StSynDet] = 1'b1;
              end else begin
                held_d = rxq_head[7:0];
                status_d[urm_pkg::StRxRdy] = 1'b1;
              end
            end
            rx_timer_d = (rx_en_q && rx_cnt1 != '0) ? delay_val : 16'd0;
          end
          if (tx_fire) begin
            if (tx_en_q && tx_count != '0) begin
              txq_ctl.pop = 1'b1;
              tx_cnt1     = tx_count - TXCW'(1);
              if (loop_q) begin
                rxq_wdata = {1'b0, txq_head};
                if (rx_cnt1 == RXCW'(RX_DEPTH)) begin
                  drop_d = 1'b1;
                end else begin
                  rxq_ctl.push = 1'b1;
                  if (rx_en_q && rx_timer_d == 16'd0) begin
                    rx_timer_d = delay_val;
                  end
                end
              end else begin
                txv_d = 1'b1;
                txb_d = txq_head;
              end
              status_d[urm_pkg::StTxRdy] = 1'b1;
              if (tx_cnt1 == '0) begin
                status_d[urm_pkg::StTxE] = 1'b1;
              end
            end
            tx_timer_d = (tx_en_q && tx_cnt1 != '0) ? delay_val : 16'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  urm_queue #(
    .DW    (RXW),
    .DEPTH (RX_DEPTH)
  ) u_rxq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (rxq_ctl),
    .push_data_i (rxq_wdata),
    .head_data_o (rxq_head),
    .count_o     (rx_count)
  );

  urm_queue #(
    .DW    (8),
    .DEPTH (TX_DEPTH)
  ) u_txq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (txq_ctl),
    .push_data_i (txq_wdata),
    .head_data_o (txq_head),
    .count_o     (tx_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q     <= urm_pkg::DelayReset;
      loop_q      <= 1'b0;
      phase_q     <= urm_pkg::PhClear;
      held_q      <= urm_pkg::HeldReset;
      status_q    <= urm_pkg::StatusReset;
      rx_en_q     <= 1'b0;
      tx_en_q     <= 1'b0;
      dtr_q       <= 1'b0;
      rts_q       <= 1'b0;
      rx_timer_q  <= 16'd0;
      tx_timer_q  <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == urm_pkg::CfgDelay) begin
          delay_q <= cfg_wdata_i;
        end else begin
          loop_q <= cfg_wdata_i[0];
        end
      end
      phase_q     <= phase_d;
      held_q      <= held_d;
      status_q    <= status_d;
      rx_en_q     <= rx_en_d;
      tx_en_q     <= tx_en_d;
      dtr_q       <= dtr_d;
      rts_q       <= rts_d;
      rx_timer_q  <= rx_timer_d;
      tx_timer_q  <= tx_timer_d;
      out_valid_q <= out_valid_d;
    end
  end

  // hold the result item while it is stalled
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q   <= rd_d;
      txv_q  <= txv_d;
      txb_q  <= txb_d;
      drop_q <= drop_d;
    end
  end

  logic [7:0] out_status_q;
  logic       out_dtr_q, out_rts_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_status_q <= status_d;
      out_dtr_q    <= dtr_d;
      out_rts_q    <= rts_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = rd_q;
  assign status_byte_o = out_status_q;
  assign dtr_out_o     = out_dtr_q;
  assign rts_out_o     = out_rts_q;
  assign tx_valid_o    = txv_q;
  assign tx_byte_o     = txb_q;
  assign rx_dropped_o  = drop_q;

`ifndef SYNTHESIS
  a_txe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q[urm_pkg::StTxE] == (tx_count == '0))
    else $error("TXE out of step with transmit queue fill");

  a_txrdy_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !status_q[urm_pkg::StTxRdy] |-> (tx_count == TXCW'(TX_DEPTH)))
    else $error("TXRDY low while transmit queue has room");

  a_rx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_count <= RXCW'(RX_DEPTH))
    else $error("receive queue overfilled");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && drop_d) |-> (rx_cnt1 == RXCW'(RX_DEPTH) && !rxq_ctl.push))
    else $error("item dropped while receive queue had room");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the USART register model. A short table of
// directed items is followed by phases of random traffic under changing
// event delay and loopback settings; every result is compared field by field
// with a cycle-free model of the registers, queues and event countdowns, or with fixed values for checked rows.
// ----------------------------------------------------------------------------
module tb_top;
  import urm_pkg::*;

  localparam int RxDepth = int'(RxDepthDefault);
  localparam int TxDepth = int'(TxDepthDefault);
  localparam logic [2:0] CmdNone = 3'd7;

  // command word bits
  localparam int CwTxEn   = 0;
  localparam int CwDtr    = 1;
  localparam int CwRxEn   = 2;
  localparam int CwRts    = 3;
  localparam int CwErrRst = 4;
  localparam int CwIntRst = 6;
  // mode word: baud field and single sync character select
  localparam int ModeSingleSync = 7;

  localparam int PhaseItems = 78;
  localparam int NumPhases  = 9;

  typedef struct packed {
    logic [7:0] rd;
    logic [7:0] st;
    logic       dtr;
    logic       rts;
    logic       txv;
    logic [7:0] txb;
    logic       drop;
  } usart_result_t;

  typedef struct packed {
    logic [2:0]    cmd;
    logic          addr;
    logic [7:0]    data;
    logic          level;
    logic          checked;
    usart_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  wire         in_stall;
  logic [2:0]  command = '0;
  logic        addr = 1'b0;
  logic [7:0]  data = '0;
  logic        level = 1'b0;
  wire         out_valid;
  logic        out_stall = 1'b0;
  wire  [7:0]  read_data;
  wire  [7:0]  status_byte;
  wire         dtr_out;
  wire         rts_out;
  wire         tx_valid;
  wire  [7:0]  tx_byte;
  wire         rx_dropped;

  usart_register_model DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .command_i    (command),
    .addr_i       (addr),
    .data_i       (data),
    .level_i      (level),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .read_data_o  (read_data),
    .status_byte_o(status_byte),
    .dtr_out_o    (dtr_out),
    .rts_out_o    (rts_out),
    .tx_valid_o   (tx_valid),
    .tx_byte_o    (tx_byte),
    .rx_dropped_o (rx_dropped)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // model state
  logic [15:0] delay_q;
  logic        loop_q;
  logic [2:0]  mode_ph;
  logic [7:0]  held_q;
  logic [7:0]  stat_q;
  logic        rx_on;
  logic        tx_on;
  logic        dtr_q;
  logic        rts_q;
  logic [8:0]  rxq [RxDepth];
  int          rx_hd;
  int          rx_n;
  logic [7:0]  txq [TxDepth];
  int          tx_hd;
  int          tx_n;
  int          rx_tick;
  int          tx_tick;

  usart_result_t pending_results [$];
  int errors = 0;
  int items_sent = 0;
  int burst_left = 0;

  function automatic void usart_reset_state();
    delay_q = DelayReset;
    loop_q  = 1'b0;
    mode_ph = PhClear;
    held_q  = HeldReset;
    stat_q  = StatusReset;
    rx_on   = 1'b0;
    tx_on   = 1'b0;
    dtr_q   = 1'b0;
    rts_q   = 1'b0;
    rx_hd   = 0;
    rx_n    = 0;
    tx_hd   = 0;
    tx_n    = 0;
    rx_tick = 0;
    tx_tick = 0;
  endfunction

  function automatic int arm_value();
    return (delay_q == 16'd0) ? 1 : int'(delay_q);
  endfunction

  function automatic void arm_rx();
    if (rx_on && rx_n != 0 && rx_tick == 0) rx_tick = arm_value();
  endfunction

  function automatic void arm_tx();
    if (tx_on && tx_n != 0 && tx_tick == 0) tx_tick = arm_value();
  endfunction

  function automatic bit rx_enqueue(logic [8:0] v);
    if (rx_n >= RxDepth) return 1'b1;
    rxq[(rx_hd + rx_n) % RxDepth] = v;
    rx_n++;
    arm_rx();
    return 1'b0;
  endfunction

  function automatic void command_word(logic [7:0] d);
    if (d[CwIntRst]) begin
      mode_ph = PhClear;
      return;
    end
    if (d[CwErrRst]) begin
      stat_q[StPe] = 1'b0;
      stat_q[StOe] = 1'b0;
      stat_q[StFe] = 1'b0;
    end
    dtr_q = d[CwDtr];
    rts_q = d[CwRts];
    rx_on = d[CwRxEn];
    arm_rx();
    tx_on = d[CwTxEn];
    arm_tx();
  endfunction

  function automatic void bus_write(logic a, logic [7:0] d);
    if (a) begin
      case (mode_ph)
        PhClear: begin
          if (d[1:0] != 2'b00) mode_ph = PhAsync;
          else if (d[ModeSingleSync]) mode_ph = PhSync2;
          else mode_ph = PhSync1;
        end
        PhSync1: mode_ph = PhSync2;
        PhSync2: mode_ph = PhSync;
        PhAsync, PhSync: command_word(d);
        default: ;
      endcase
    end else if (stat_q[StTxRdy] && tx_n < TxDepth) begin
      txq[(tx_hd + tx_n) % TxDepth] = d;
      tx_n++;
      if (tx_n >= TxDepth) stat_q[StTxRdy] = 1'b0;
      stat_q[StTxE] = 1'b0;
      arm_tx();
    end
  endfunction

  function automatic void rx_fire();
    logic [8:0] v;
    if (rx_on && !stat_q[StRxRdy] && rx_n != 0) begin
      v = rxq[rx_hd];
      rx_hd = (rx_hd + 1) % RxDepth;
      rx_n--;
      if (v[BreakBit]) begin
        stat_q[StSynDet] = 1'b1;
      end else begin
        held_q = v[7:0];
        stat_q[StRxRdy] = 1'b1;
      end
    end
    rx_tick = (rx_on && rx_n != 0) ? arm_value() : 0;
  endfunction

  function automatic void tx_fire(inout usart_result_t r);
    logic [7:0] v;
    if (tx_on && tx_n != 0) begin
      v = txq[tx_hd];
      tx_hd = (tx_hd + 1) % TxDepth;
      tx_n--;
      if (loop_q) begin
        if (rx_enqueue({1'b0, v})) r.drop = 1'b1;
      end else begin
        r.txv = 1'b1;
        r.txb = v;
      end
      stat_q[StTxRdy] = 1'b1;
      if (tx_n == 0) stat_q[StTxE] = 1'b1;
    end
    tx_tick = (tx_on && tx_n != 0) ? arm_value() : 0;
  endfunction

  function automatic usart_result_t usart_predict(logic [2:0] c, logic a, logic [7:0] d,
                                                  logic lv);
    usart_result_t r;
    bit rx_due;
    bit tx_due;
    r = '0;
    rx_due = 1'b0;
    tx_due = 1'b0;
    case (c)
      CmdWrite: bus_write(a, d);
      CmdRead: begin
        if (a) begin
          r.rd = stat_q;
        end else begin
          stat_q[StRxRdy] = 1'b0;
          r.rd = held_q;
        end
      end
      CmdByte:  r.drop = rx_enqueue({1'b0, d});
      CmdBreak: r.drop = rx_enqueue(9'(1) << BreakBit);
      CmdDsr:   stat_q[StDsr] = lv;
      CmdClear: begin
        rx_hd = 0;
        rx_n  = 0;
      end
      CmdTick: begin
        if (rx_tick != 0) begin
          rx_tick--;
          rx_due = (rx_tick == 0);
        end
        if (tx_tick != 0) begin
          tx_tick--;
          tx_due = (tx_tick == 0);
        end
        if (rx_due) rx_fire();
        if (tx_due) tx_fire(r);
      end
      default: ;
    endcase
    r.st  = stat_q;
    r.dtr = dtr_q;
    r.rts = rts_q;
    return r;
  endfunction

  task automatic check_field(string name, int e, int a);
    if (e != a) begin
      $display("%0t: %s expected %0h got %0h", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    usart_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no item outstanding", $time);
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("read_data", int'(e.rd), int'(read_data));
        check_field("status_byte", int'(e.st), int'(status_byte));
        check_field("dtr_out", int'(e.dtr), int'(dtr_out));
        check_field("rts_out", int'(e.rts), int'(rts_out));
        check_field("tx_valid", int'(e.txv), int'(tx_valid));
        check_field("tx_byte", int'(e.txb), int'(tx_byte));
        check_field("rx_dropped", int'(e.drop), int'(rx_dropped));
      end
    end
  end

  int stall_left = 0;
  int stall_kind = 0;
  int stall_phase = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_kind = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 120);
    end
    stall_left--;
    stall_phase++;
    case (stall_kind)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_phase % 5) < 2);
    endcase
  end

  task automatic drive_item(input logic [2:0] c, input logic a, input logic [7:0] d,
                            input logic lv, input bit checked, input usart_result_t fixed);
    usart_result_t r;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    command  <= c;
    addr     <= a;
    data     <= d;
    level    <= lv;
    do begin
      @(posedge clk);
    end while (in_stall);
    r = usart_predict(c, a, d, lv);
    pending_results.push_back(checked ? fixed : r);
    items_sent++;
  endtask

  task automatic send(input logic [2:0] c, input logic a, input logic [7:0] d,
                      input logic lv);
    drive_item(c, a, d, lv, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CfgDelay) delay_q = v;
    else loop_q = v[0];
  endtask

  // internal reset if needed, mode word, sync characters and a command word that mostly enables
  task automatic bring_up();
    logic [7:0] w;
    if (mode_ph == PhAsync || mode_ph == PhSync) begin
      w = 8'($urandom);
      w[CwIntRst] = 1'b1;
      send(CmdWrite, 1'b1, w, 1'($urandom));
    end
    while (mode_ph != PhAsync && mode_ph != PhSync) begin
      w = 8'($urandom);
      if (mode_ph == PhClear) begin
        if ($urandom_range(0, 3) == 0) w[1:0] = 2'b00;
        else if (w[1:0] == 2'b00) w[1:0] = 2'b01;
      end
      send(CmdWrite, 1'b1, w, 1'($urandom));
    end
    w = 8'($urandom);
    w[CwIntRst] = 1'b0;
    w[CwTxEn] = ($urandom_range(0, 7) != 0);
    w[CwRxEn] = ($urandom_range(0, 7) != 0);
    send(CmdWrite, 1'b1, w, 1'($urandom));
  endtask

  task automatic random_item();
    int pick;
    int n;
    logic [7:0] d;
    pick = $urandom_range(0, 99);
    d = 8'($urandom);
    if (pick < 20) begin
      send(CmdWrite, 1'b0, d, 1'($urandom));
    end else if (pick < 28) begin
      send(CmdRead, 1'b0, d, 1'($urandom));
    end else if (pick < 36) begin
      send(CmdRead, 1'b1, d, 1'($urandom));
    end else if (pick < 50) begin
      send(CmdByte, 1'($urandom), d, 1'($urandom));
    end else if (pick < 55) begin
      send(CmdBreak, 1'($urandom), d, 1'($urandom));
    end else if (pick < 60) begin
      send(CmdDsr, 1'($urandom), d, 1'($urandom));
    end else if (pick < 63) begin
      send(CmdClear, 1'($urandom), d, 1'($urandom));
    end else if (pick < 66) begin
      if ($urandom_range(0, 4) != 0) d[CwIntRst] = 1'b0;
      send(CmdWrite, 1'b1, d, 1'($urandom));
    end else if (pick < 68) begin
      send(CmdNone, 1'($urandom), d, 1'($urandom));
    end else if (pick < 70) begin
      n = $urandom_range(16, 20);
      repeat (n) send(($urandom_range(0, 4) == 0) ? CmdBreak : CmdByte, 1'($urandom),
                      8'($urandom), 1'($urandom));
    end else begin
      n = $urandom_range(1, (arm_value() <= 8) ? arm_value() * 3 : 24);
      repeat (n) send(CmdTick, 1'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  function automatic stim_row_t mk_row(logic [2:0] c, logic a, logic [7:0] d, logic lv);
    stim_row_t s;
    s = '0;
    s.cmd   = c;
    s.addr  = a;
    s.data  = d;
    s.level = lv;
    return s;
  endfunction

  function automatic stim_row_t mk_checked(logic [2:0] c, logic a, logic [7:0] d, logic lv,
                                           logic [7:0] rd, logic [7:0] st);
    stim_row_t s;
    s = mk_row(c, a, d, lv);
    s.checked = 1'b1;
    s.res.rd  = rd;
    s.res.st  = st;
    return s;
  endfunction

  int phase_delay [NumPhases] = '{1, 2, 0, 3, 1, 65535, 4, 12, 1};
  bit phase_loop  [NumPhases] = '{0, 1, 0, 1, 1, 0, 0, 1, 0};

  initial begin
    stim_row_t directed [$];
    int target;
    usart_reset_state();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_cfg(CfgDelay, 16'd1);
    write_cfg(CfgLoopback, 16'd0);

    directed.push_back(mk_checked(CmdRead, 1'b1, 8'h00, 1'b0, 8'h05, 8'h05));
    directed.push_back(mk_checked(CmdRead, 1'b0, 8'h00, 1'b0, 8'hff, 8'h05));
    directed.push_back(mk_checked(CmdDsr, 1'b0, 8'h00, 1'b1, 8'h00, 8'h85));
    directed.push_back(mk_checked(CmdNone, 1'b1, 8'hff, 1'b1, 8'h00, 8'h85));
    directed.push_back(mk_checked(CmdDsr, 1'b1, 8'hff, 1'b0, 8'h00, 8'h05));
    directed.push_back(mk_row(CmdWrite, 1'b1, 8'h00, 1'b0));
    directed.push_back(mk_row(CmdWrite, 1'b1, 8'h12, 1'b0));
    directed.push_back(mk_row(CmdWrite, 1'b1, 8'h34, 1'b0));
    directed.push_back(mk_row(CmdWrite, 1'b1, 8'h40, 1'b0));
    directed.push_back(mk_row(CmdWrite, 1'b1, 8'h80, 1'b0));
    directed.push_back(mk_row(CmdWrite, 1'b1, 8'h55, 1'b0));
    directed.push_back(mk_row(CmdWrite, 1'b1, 8'hff, 1'b1));
    directed.push_back(mk_row(CmdWrite, 1'b1, 8'hce, 1'b0));
    directed.push_back(mk_row(CmdWrite, 1'b1, 8'h00, 1'b0));
    directed.push_back(mk_row(CmdWrite, 1'b0, 8'h00, 1'b0));
    directed.push_back(mk_row(CmdWrite, 1'b0, 8'hff, 1'b0));
    directed.push_back(mk_row(CmdWrite, 1'b0, 8'ha5, 1'b0));
    directed.push_back(mk_row(CmdWrite, 1'b0, 8'h5a, 1'b0));
    directed.push_back(mk_row(CmdWrite, 1'b0, 8'h11, 1'b0));
    directed.push_back(mk_row(CmdByte, 1'b0, 8'hff, 1'b0));
    directed.push_back(mk_row(CmdBreak, 1'b1, 8'h77, 1'b1));
    directed.push_back(mk_row(CmdWrite, 1'b1, 8'h3f, 1'b0));
    directed.push_back(mk_row(CmdTick, 1'b0, 8'h00, 1'b0));
    directed.push_back(mk_row(CmdTick, 1'b1, 8'hff, 1'b1));
    directed.push_back(mk_row(CmdRead, 1'b0, 8'h00, 1'b0));
    directed.push_back(mk_row(CmdTick, 1'b0, 8'h00, 1'b0));
    directed.push_back(mk_row(CmdByte, 1'b0, 8'h00, 1'b0));
    directed.push_back(mk_row(CmdClear, 1'b0, 8'h00, 1'b0));
    directed.push_back(mk_row(CmdTick, 1'b0, 8'h00, 1'b0));
    directed.push_back(mk_row(CmdRead, 1'b1, 8'h00, 1'b0));

    foreach (directed[i])
      drive_item(directed[i].cmd, directed[i].addr, directed[i].data, directed[i].level,
                 directed[i].checked, directed[i].res);

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      write_cfg(CfgDelay, 16'(phase_delay[p]));
      write_cfg(CfgLoopback, 16'(phase_loop[p]));
      bring_up();
      target = items_sent + PhaseItems;
      while (items_sent < target) begin
        if (mode_ph != PhAsync && mode_ph != PhSync && $urandom_range(0, 3) == 0)
          bring_up();
        else
          random_item();
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0)
      $display("[usart_register_model] OK");
    else
      $display("[usart_register_model] ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("[usart_register_model] ERROR");
    $finish;
  end

endmodule
